### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int VALUE_W   = 32;
  localparam int PRIO_W    = 16;
  localparam int FILL_W    = 5;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // operation broadcast to every cell; enq/deq only when it changes the queue
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic                      clk,
  input  wire cmd_t                      cmd,
  input  wire logic                      occupied,
  input  wire logic                      ge_left,
  input  wire logic signed [VALUE_W-1:0] value_left,
  input  wire logic signed [PRIO_W-1:0]  prio_left,
  input  wire logic signed [VALUE_W-1:0] value_right,
  input  wire logic signed [PRIO_W-1:0]  prio_right,
  output logic                           ge,
  output logic signed [VALUE_W-1:0]      value_q,
  output logic signed [PRIO_W-1:0]       prio_q
);

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic signed [PRIO_W-1:0]  prio_r, prio_nxt;

  // stays in place when it outranks or ties the new entry
  assign ge = occupied && (prio_r >= cmd.prio);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !ge) begin
      if (ge_left) begin
        value_nxt = cmd.value;
        prio_nxt  = cmd.prio;
      end else begin
        value_nxt = value_left;
        prio_nxt  = prio_left;
      end
    end else if (cmd.deq) begin
      value_nxt = value_right;
      prio_nxt  = prio_right;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value_q = value_r;
  assign prio_q  = prio_r;

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// The result is registered and appears on the out_ channel in the cycle after the input transfer.
// Throughput: one operation per cycle; in_tready stays high while the result
//   register is empty or being drained in the same cycle.
// Every operation is resolved by the row of DEPTH cells, each comparing with the
//   broadcast operation and its left neighbour.
// Reset (rst_n low, synchronous) empties the queue and result register; cells keep data.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] item_value, [47:32] item_priority
  input  wire logic [0:0]  in_tuser,   // [0] mode
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] out_value, [36:32] fill_level, rest zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                     in_xfer;
  logic                     is_deq;
  logic                     full, empty;
  cmd_t                     cmd;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                  status_r, status_nxt;
  logic [FILL_W-1:0]        fill_r;

  logic                      ge_a    [DEPTH];
  logic signed [VALUE_W-1:0] value_a [DEPTH];
  logic signed [PRIO_W-1:0]  prio_a  [DEPTH];

  // the result register frees up in the cycle it is drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_deq    = in_tuser[0];

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign cmd.enq   = in_xfer && !is_deq && !full;
  assign cmd.deq   = in_xfer && is_deq && !empty;
  assign cmd.value = in_tdata[31:0];
  assign cmd.prio  = in_tdata[47:32];

  // Cell 0 is the head. New entry lands in the first cell that does not
  // outrank or tie it; everything behind moves one step right. A dequeue
  // moves every cell one step left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                      ge_left;
    logic signed [VALUE_W-1:0] value_left, value_right;
    logic signed [PRIO_W-1:0]  prio_left, prio_right;

    if (i == 0) begin : g_head
      assign ge_left    = 1'b1;
      assign value_left = '0;
      assign prio_left  = '0;
    end else begin : g_mid
      assign ge_left    = ge_a[i-1];
      assign value_left = value_a[i-1];
      assign prio_left  = prio_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign value_right = '0;
      assign prio_right  = '0;
    end else begin : g_body
      assign value_right = value_a[i+1];
      assign prio_right  = prio_a[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (IDX < count_r),
      .ge_left     (ge_left),
      .value_left  (value_left),
      .prio_left   (prio_left),
      .value_right (value_right),
      .prio_right  (prio_right),
      .ge          (ge_a[i]),
      .value_q     (value_a[i]),
      .prio_q      (prio_a[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_value_nxt = '0;
    status_nxt    = ST_ENQ;
    if (is_deq) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt    = ST_DEQ;
        out_value_nxt = value_a[0];
        count_nxt     = count_r - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_value_r <= out_value_nxt;
      status_r    <= status_nxt;
      fill_r      <= FILL_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, fill_r, out_value_r};
  assign out_tuser  = status_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !is_deq && full) |=> (status_r == ST_FULL && count_r == $past(count_r)))
    else $error("enqueue on full queue not dropped");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_deq && !empty) |=> (count_r == $past(count_r) - CNT_W'(1) &&
                                       out_tuser == ST_DEQ))
    else $error("dequeue did not shrink queue");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (prio_a[0] >= prio_a[1]))
    else $error("head entries out of priority order");

endmodule

`default_nettype wire
